// ----- rtl/log_timestamp_to_number_assert.svh -----
// Assertion macros used by the top RTL file of the timestamp converter.
`ifndef LOG_TIMESTAMP_TO_NUMBER_ASSERT_SVH
`define LOG_TIMESTAMP_TO_NUMBER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lts: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lts: next-cycle check failed");

`endif

// ----- rtl/lts_pkg.sv -----
package lts_pkg;

  typedef enum logic [2:0] {
    PH_MONTH,
    PH_SKIP1,
    PH_DAY,
    PH_SKIP2,
    PH_HOUR,
    PH_MINUTE,
    PH_SECOND
  } phase_t;

  // Decoded fields of one finished timestamp; year, hour, minute and second are range-checked.
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [6:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } fields_t;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  char_index;
  } parse_stat_t;

  localparam logic [13:0] YEAR_RESET = 14'd2025;
  localparam logic [13:0] YEAR_MAX   = 14'd9999;
  localparam logic [6:0]  HOUR_MAX   = 7'd23;
  localparam logic [6:0]  MINSEC_MAX = 7'd59;
  localparam logic [10:0] ACC_MAX    = 11'd99;

  localparam logic [16:0] SCALE_1E5  = 17'd100000;
  localparam logic [19:0] SCALE_1E6  = 20'd1000000;
  localparam logic [13:0] SCALE_1E4  = 14'd10000;
  localparam logic [6:0]  SCALE_1E2  = 7'd100;
  localparam logic [46:0] DATE_MAX   = 47'd99991299235959;

  // Character codes.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_UP_J  = 8'h4A;
  localparam logic [7:0] CH_UP_M  = 8'h4D;
  localparam logic [7:0] CH_UP_N  = 8'h4E;
  localparam logic [7:0] CH_UP_O  = 8'h4F;
  localparam logic [7:0] CH_UP_S  = 8'h53;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_E  = 8'h65;
  localparam logic [7:0] CH_LO_N  = 8'h6E;
  localparam logic [7:0] CH_LO_R  = 8'h72;

  // Months by number.
  localparam logic [3:0] MON_JAN = 4'd1;
  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_MAR = 4'd3;
  localparam logic [3:0] MON_APR = 4'd4;
  localparam logic [3:0] MON_MAY = 4'd5;
  localparam logic [3:0] MON_JUN = 4'd6;
  localparam logic [3:0] MON_JUL = 4'd7;
  localparam logic [3:0] MON_AUG = 4'd8;
  localparam logic [3:0] MON_SEP = 4'd9;
  localparam logic [3:0] MON_OCT = 4'd10;
  localparam logic [3:0] MON_NOV = 4'd11;
  localparam logic [3:0] MON_DEC = 4'd12;

  // Shift one decimal digit into a two-digit accumulator, saturating at 99.
  // Anything that is not a digit leaves the accumulator unchanged.
  function automatic logic [6:0] acc_digit(input logic [6:0] acc, input logic [7:0] c);
    logic [7:0]  rel;
    logic [10:0] v;
    rel = c - CH_ZERO;
    v   = 11'(acc) * 11'd10 + 11'(rel[3:0]);
    if (c < CH_ZERO || c > CH_NINE) begin
      return acc;
    end else if (v > ACC_MAX) begin
      return ACC_MAX[6:0];
    end else begin
      return v[6:0];
    end
  endfunction

  function automatic logic [3:0] month_number(input logic [7:0] c0, input logic [7:0] c1,
                                              input logic [7:0] c2);
    logic [3:0] m;
    priority if (c0 == CH_UP_J) begin
      priority if (c1 == CH_LO_A) m = MON_JAN;
      else if (c2 == CH_LO_N)     m = MON_JUN;
      else                        m = MON_JUL;
    end else if (c0 == CH_UP_F) begin
      m = MON_FEB;
    end else if (c0 == CH_UP_M) begin
      m = (c2 == CH_LO_R) ? MON_MAR : MON_MAY;
    end else if (c0 == CH_UP_A) begin
      m = (c2 == CH_LO_R) ? MON_APR : MON_AUG;
    end else if (c0 == CH_UP_S) begin
      m = MON_SEP;
    end else if (c0 == CH_UP_O) begin
      m = MON_OCT;
    end else if (c0 == CH_UP_N) begin
      m = MON_NOV;
    end else if (c0 == CH_LO_E) begin
      m = MON_JAN;
    end else begin
      m = MON_DEC;
    end
    return m;
  endfunction

endpackage

// ----- rtl/lts_parse.sv -----
module lts_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  logic [7:0]           char_in,
  input  logic                 is_last,
  input  logic [13:0]          base_year,
  output lts_pkg::fields_t     fields,
  output lts_pkg::parse_stat_t stat
);

  lts_pkg::phase_t phase_r, phase_nxt;
  logic [1:0] char_index_r, char_index_nxt;
  logic [7:0] month_chars_r [3];
  logic [7:0] month_chars_nxt [3];
  logic [6:0] day_acc_r, day_acc_nxt;
  logic [6:0] hour_acc_r, hour_acc_nxt;
  logic [6:0] minute_acc_r, minute_acc_nxt;
  logic [6:0] second_acc_r, second_acc_nxt;
  logic       time_has_hour, time_has_minsec;

  // Phase transitions for one character.
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      lts_pkg::PH_MONTH: begin
        if (char_index_r == 2'd2) phase_nxt = lts_pkg::PH_SKIP1;
      end
      lts_pkg::PH_SKIP1: begin
        if (char_in != lts_pkg::CH_SPACE) phase_nxt = lts_pkg::PH_DAY;
      end
      lts_pkg::PH_DAY: begin
        if (char_in == lts_pkg::CH_SPACE) phase_nxt = lts_pkg::PH_SKIP2;
      end
      lts_pkg::PH_SKIP2: begin
        if (char_in == lts_pkg::CH_COLON) phase_nxt = lts_pkg::PH_MINUTE;
        else if (char_in != lts_pkg::CH_SPACE) phase_nxt = lts_pkg::PH_HOUR;
      end
      lts_pkg::PH_HOUR: begin
        if (char_in == lts_pkg::CH_COLON) phase_nxt = lts_pkg::PH_MINUTE;
      end
      lts_pkg::PH_MINUTE: begin
        if (char_in == lts_pkg::CH_COLON) phase_nxt = lts_pkg::PH_SECOND;
      end
      lts_pkg::PH_SECOND: phase_nxt = lts_pkg::PH_SECOND;
      default:            phase_nxt = lts_pkg::PH_MONTH;
    endcase
  end

  // Datapath updates for one character.
  always_comb begin
    char_index_nxt  = char_index_r;
    month_chars_nxt = month_chars_r;
    day_acc_nxt     = day_acc_r;
    hour_acc_nxt    = hour_acc_r;
    minute_acc_nxt  = minute_acc_r;
    second_acc_nxt  = second_acc_r;
    unique case (phase_r)
      lts_pkg::PH_MONTH: begin
        month_chars_nxt[char_index_r] = char_in;
        char_index_nxt = char_index_r + 2'd1;
      end
      lts_pkg::PH_SKIP1: begin
        if (char_in != lts_pkg::CH_SPACE) day_acc_nxt = lts_pkg::acc_digit(day_acc_r, char_in);
      end
      lts_pkg::PH_DAY: begin
        if (char_in != lts_pkg::CH_SPACE) day_acc_nxt = lts_pkg::acc_digit(day_acc_r, char_in);
      end
      lts_pkg::PH_SKIP2: begin
        if (char_in != lts_pkg::CH_SPACE && char_in != lts_pkg::CH_COLON) begin
          hour_acc_nxt = lts_pkg::acc_digit(hour_acc_r, char_in);
        end
      end
      lts_pkg::PH_HOUR: begin
        if (char_in != lts_pkg::CH_COLON) hour_acc_nxt = lts_pkg::acc_digit(hour_acc_r, char_in);
      end
      lts_pkg::PH_MINUTE: begin
        if (char_in != lts_pkg::CH_COLON) begin
          minute_acc_nxt = lts_pkg::acc_digit(minute_acc_r, char_in);
        end
      end
      lts_pkg::PH_SECOND: begin
        second_acc_nxt = lts_pkg::acc_digit(second_acc_r, char_in);
      end
      default: begin
        char_index_nxt = char_index_r;
      end
    endcase
  end

  // The hour counts once a colon has closed it; minute and second need the second colon.
  always_comb begin
    time_has_hour   = (phase_nxt == lts_pkg::PH_MINUTE) || (phase_nxt == lts_pkg::PH_SECOND);
    time_has_minsec = (phase_nxt == lts_pkg::PH_SECOND);
    fields.year   = (base_year > lts_pkg::YEAR_MAX) ? lts_pkg::YEAR_MAX : base_year;
    fields.month  = lts_pkg::month_number(month_chars_nxt[0], month_chars_nxt[1],
                                          month_chars_nxt[2]);
    fields.day    = day_acc_nxt;
    fields.hour   = (time_has_hour && hour_acc_nxt <= lts_pkg::HOUR_MAX) ? hour_acc_nxt[4:0]
                                                                         : 5'd0;
    fields.minute = (time_has_minsec && minute_acc_nxt <= lts_pkg::MINSEC_MAX)
                    ? minute_acc_nxt[5:0] : 6'd0;
    fields.second = (time_has_minsec && second_acc_nxt <= lts_pkg::MINSEC_MAX)
                    ? second_acc_nxt[5:0] : 6'd0;
    stat.phase      = phase_r;
    stat.char_index = char_index_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && is_last)) begin
      phase_r        <= lts_pkg::PH_MONTH;
      char_index_r   <= 2'd0;
      month_chars_r  <= '{default: 8'd0};
      day_acc_r      <= 7'd0;
      hour_acc_r     <= 7'd0;
      minute_acc_r   <= 7'd0;
      second_acc_r   <= 7'd0;
    end else if (take) begin
      phase_r        <= phase_nxt;
      char_index_r   <= char_index_nxt;
      month_chars_r  <= month_chars_nxt;
      day_acc_r      <= day_acc_nxt;
      hour_acc_r     <= hour_acc_nxt;
      minute_acc_r   <= minute_acc_nxt;
      second_acc_r   <= second_acc_nxt;
    end
  end

endmodule

// ----- rtl/lts_pack.sv -----
module lts_pack (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  lts_pkg::fields_t fields,
  output logic             load_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [46:0]      out_date_value
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  lts_pkg::fields_t f1_r;
  logic [30:0] yr5_r, yr5_nxt;
  logic [10:0] md_r, md_nxt;
  logic [17:0] hms_r, hms_nxt;
  logic [46:0] yrt_r, yrt_nxt;
  logic [30:0] low_r, low_nxt;
  logic [46:0] date_r, date_nxt;

  // A stage may load when it is empty or its word moves on in the same cycle.
  always_comb begin
    en4 = !v4_r || out_ready;
    en3 = !v3_r || en4;
    en2 = !v2_r || en3;
    en1 = !v1_r || en2;
    load_ready = en1;
  end

  always_comb begin
    yr5_nxt = 31'(31'(f1_r.year) * 31'(lts_pkg::SCALE_1E5));
    md_nxt  = 11'(11'(f1_r.month) * 11'(lts_pkg::SCALE_1E2) + 11'(f1_r.day));
    hms_nxt = 18'(18'(f1_r.hour) * 18'(lts_pkg::SCALE_1E4)
                  + 18'(f1_r.minute) * 18'(lts_pkg::SCALE_1E2) + 18'(f1_r.second));
    yrt_nxt = 47'(47'(yr5_r) * 47'(lts_pkg::SCALE_1E5));
    low_nxt = 31'(31'(md_r) * 31'(lts_pkg::SCALE_1E6) + 31'(hms_r));
    date_nxt = yrt_r + 47'(low_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= load;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) f1_r <= fields;
    if (en2) begin
      yr5_r <= yr5_nxt;
      md_r  <= md_nxt;
      hms_r <= hms_nxt;
    end
    if (en3) begin
      yrt_r <= yrt_nxt;
      low_r <= low_nxt;
    end
    if (en4) date_r <= date_nxt;
  end

  assign out_valid      = v4_r;
  assign out_date_value = date_r;

endmodule

// ----- rtl/log_timestamp_to_number.sv -----
// Log timestamp converter. A string such as "Jun  5 14:03:22" enters one
// character per word on the in_ channel (in_char_in, with in_is_last marking
// the final character). For each string the out_ channel delivers one word,
// out_date_value, packed as decimal YYYYMMDDHHMMSS so that values compare in
// time order. Characters before the last produce nothing on the output.
// The cfg_ port writes the year (cfg_we with cfg_data, no wait); it is taken
// for a string when that string's last character is accepted.
// One character is taken per cycle while in_ready is high. A result reaches
// out_valid through four registers: the first holds the decoded fields, the
// next two hold the partial products of the constant multiplies, and the
// last is the output register.
// When the receiver stalls, up to four results queue in the stages; in_ready
// drops only once all four are full and the output word is not taken.
// Reset (synchronous, active low) empties the stages, clears the parser back
// to the month characters and sets the year to 2025.
`include "log_timestamp_to_number_assert.svh"

module log_timestamp_to_number (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_in,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [46:0] out_date_value,
  input  logic        cfg_we,
  input  logic [13:0] cfg_data
);

  logic [13:0]          base_year_r;
  logic                 in_take;
  lts_pkg::fields_t     fields;
  lts_pkg::parse_stat_t stat;

  // Year register; a value above 9999 is clamped at the parser.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_year_r <= lts_pkg::YEAR_RESET;
    end else if (cfg_we) begin
      base_year_r <= cfg_data;
    end
  end

  assign in_take = in_valid && in_ready;

  // Character parser: phase tracking and the digit accumulators.
  lts_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (in_take),
    .char_in   (in_char_in),
    .is_last   (in_is_last),
    .base_year (base_year_r),
    .fields    (fields),
    .stat      (stat)
  );

  // Result pipeline: turns the decoded fields into the packed number.
  lts_pack u_pack (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (in_take && in_is_last),
    .fields         (fields),
    .load_ready     (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_date_value (out_date_value)
  );

  // The last character always leaves the parser ready for a fresh month.
  `LTS_ASSERT_NEXT(a_clear_after_last, clk, rst_n, in_take && in_is_last,
                   stat.phase == lts_pkg::PH_MONTH && stat.char_index == 2'd0)

  // Input backpressure only happens behind a stalled, full output.
  `LTS_ASSERT_IMPLY(a_stall_cause, clk, rst_n, !in_ready, out_valid && !out_ready)

  // Every packed result stays within the largest legal timestamp.
  `LTS_ASSERT_IMPLY(a_result_range, clk, rst_n, out_valid,
                    out_date_value <= lts_pkg::DATE_MAX)

endmodule

// ----- tb/tb_log_timestamp_to_number.sv -----
`timescale 1ns / 100ps

module tb_log_timestamp_to_number;

  // Cycles without any accepted word before the run is declared hung. The slowest
  // legal quiet stretch is a full drain of the stages behind a stalling receiver
  // plus the settle time before a year write.
  localparam int WATCHDOG_LIMIT = 1000;
  // Cycles allowed after the last expected word: four pipeline stages plus margin.
  localparam int SETTLE_CYCLES  = 8;
  // Characters sent per year setting in the random part.
  localparam int CHARS_PER_YEAR = 100;
  localparam int YEAR_STEPS     = 6;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_char_in = 8'h00;
  logic        in_is_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [46:0] out_date_value;
  logic        cfg_we = 1'b0;
  logic [13:0] cfg_data = 14'd0;

  always #10 clk = ~clk;

  log_timestamp_to_number u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_in     (in_char_in),
    .in_is_last     (in_is_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_date_value (out_date_value),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data)
  );

  // Packed timestamps that the converter still owes, oldest first.
  logic [46:0] pending_dates[$];
  int          fail_count = 0;
  int          idle_cycles = 0;

  // ---------------------------------------------------------------------------
  // Parser mirror. It follows the converter character by character: three month
  // letters, optional spaces, the day, more spaces, then hour:minute:second.
  // ---------------------------------------------------------------------------
  lts_pkg::phase_t ps_phase;
  logic [1:0]  ps_count;
  logic [7:0]  ps_month [3];
  logic [6:0]  ps_day;
  logic [6:0]  ps_hour;
  logic [6:0]  ps_minute;
  logic [6:0]  ps_second;
  logic [13:0] year_reg;

  // Append one decimal digit to a two-digit field. Anything that is not a digit
  // leaves the field alone, and a value that would pass 99 is pinned at 99.
  function automatic logic [6:0] digit_push(input logic [6:0] acc, input logic [7:0] c);
    int unsigned v;
    if (c < lts_pkg::CH_ZERO || c > lts_pkg::CH_NINE) begin
      return acc;
    end
    v = acc * 10 + (c - lts_pkg::CH_ZERO);
    return (v > lts_pkg::ACC_MAX) ? 7'(lts_pkg::ACC_MAX) : v[6:0];
  endfunction

  // Month from the first three letters. Only a few letters are looked at, so
  // "Jxx" falls to July, a lowercase 'e' opens January and junk means December.
  function automatic logic [3:0] month_code(input logic [7:0] c0, input logic [7:0] c1,
                                            input logic [7:0] c2);
    if (c0 == lts_pkg::CH_UP_J) begin
      if (c1 == lts_pkg::CH_LO_A) return lts_pkg::MON_JAN;
      if (c2 == lts_pkg::CH_LO_N) return lts_pkg::MON_JUN;
      return lts_pkg::MON_JUL;
    end
    if (c0 == lts_pkg::CH_UP_F) return lts_pkg::MON_FEB;
    if (c0 == lts_pkg::CH_UP_M) begin
      return (c2 == lts_pkg::CH_LO_R) ? lts_pkg::MON_MAR : lts_pkg::MON_MAY;
    end
    if (c0 == lts_pkg::CH_UP_A) begin
      return (c2 == lts_pkg::CH_LO_R) ? lts_pkg::MON_APR : lts_pkg::MON_AUG;
    end
    if (c0 == lts_pkg::CH_UP_S) return lts_pkg::MON_SEP;
    if (c0 == lts_pkg::CH_UP_O) return lts_pkg::MON_OCT;
    if (c0 == lts_pkg::CH_UP_N) return lts_pkg::MON_NOV;
    if (c0 == lts_pkg::CH_LO_E) return lts_pkg::MON_JAN;
    return lts_pkg::MON_DEC;
  endfunction

  task automatic clear_parse();
    ps_phase  = lts_pkg::PH_MONTH;
    ps_count  = 2'd0;
    ps_month[0] = 8'h00;
    ps_month[1] = 8'h00;
    ps_month[2] = 8'h00;
    ps_day    = 7'd0;
    ps_hour   = 7'd0;
    ps_minute = 7'd0;
    ps_second = 7'd0;
  endtask

  // Advance the mirror by one accepted character. On the last character of a
  // string it hands back the packed timestamp and starts over.
  task automatic track_char(input logic [7:0] c, input logic last, output bit has_date,
                            output logic [46:0] date);
    logic [13:0]     yr;
    logic [6:0]      hr;
    logic [6:0]      mi;
    logic [6:0]      se;
    longint unsigned packed_date;
    case (ps_phase)
      lts_pkg::PH_MONTH: begin
        ps_month[ps_count] = c;
        if (ps_count == 2'd2) begin
          ps_count = 2'd3;
          ps_phase = lts_pkg::PH_SKIP1;
        end else begin
          ps_count = ps_count + 2'd1;
        end
      end
      lts_pkg::PH_SKIP1: begin
        if (c != lts_pkg::CH_SPACE) begin
          ps_phase = lts_pkg::PH_DAY;
          ps_day   = digit_push(ps_day, c);
        end
      end
      lts_pkg::PH_DAY: begin
        if (c == lts_pkg::CH_SPACE) ps_phase = lts_pkg::PH_SKIP2;
        else ps_day = digit_push(ps_day, c);
      end
      lts_pkg::PH_SKIP2: begin
        // A colon right after the spaces skips the hour altogether.
        if (c == lts_pkg::CH_COLON) begin
          ps_phase = lts_pkg::PH_MINUTE;
        end else if (c != lts_pkg::CH_SPACE) begin
          ps_phase = lts_pkg::PH_HOUR;
          ps_hour  = digit_push(ps_hour, c);
        end
      end
      lts_pkg::PH_HOUR: begin
        if (c == lts_pkg::CH_COLON) ps_phase = lts_pkg::PH_MINUTE;
        else ps_hour = digit_push(ps_hour, c);
      end
      lts_pkg::PH_MINUTE: begin
        if (c == lts_pkg::CH_COLON) ps_phase = lts_pkg::PH_SECOND;
        else ps_minute = digit_push(ps_minute, c);
      end
      lts_pkg::PH_SECOND: begin
        ps_second = digit_push(ps_second, c);
      end
      default: begin
      end
    endcase
    has_date = last;
    date     = '0;
    if (last) begin
      yr = (year_reg > lts_pkg::YEAR_MAX) ? lts_pkg::YEAR_MAX : year_reg;
      // The hour needs one colon behind it; minute and second need two.
      hr = (ps_phase == lts_pkg::PH_MINUTE || ps_phase == lts_pkg::PH_SECOND) ? ps_hour
                                                                                : 7'd0;
      mi = (ps_phase == lts_pkg::PH_SECOND) ? ps_minute : 7'd0;
      se = (ps_phase == lts_pkg::PH_SECOND) ? ps_second : 7'd0;
      if (hr > lts_pkg::HOUR_MAX) hr = 7'd0;
      if (mi > lts_pkg::MINSEC_MAX) mi = 7'd0;
      if (se > lts_pkg::MINSEC_MAX) se = 7'd0;
      packed_date = 64'(yr) * 64'd10000000000
                  + 64'(month_code(ps_month[0], ps_month[1], ps_month[2])) * 64'd100000000
                  + 64'(ps_day) * 64'd1000000
                  + 64'(hr) * 64'd10000
                  + 64'(mi) * 64'd100
                  + 64'(se);
      date = packed_date[46:0];
      clear_parse();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side. A word is offered at a rising edge and is taken at the first
  // rising edge where in_ready is seen high; in_ready is looked at on the
  // falling edge so that nothing hinges on event order at the rising one. A
  // row with a hand-typed timestamp queues that value instead of the mirror's.
  // ---------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c, input logic last, input bit no_gaps,
                           input bit typed, input logic [46:0] want);
    int          gap;
    bit          has_date;
    logic [46:0] date;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_char_in <= c;
    in_is_last <= last;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    track_char(c, last, has_date, date);
    if (has_date) pending_dates.push_back(typed ? want : date);
  endtask

  // Wait until every owed timestamp is out and the stages have drained.
  task automatic settle();
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_year(input logic [13:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    year_reg = value;
  endtask

  // ---------------------------------------------------------------------------
  // Random timestamp strings. Most look like real log stamps with random
  // content, including out-of-range times, overlong digit runs, missing colons
  // and stray characters; the rest are raw noise or cut short.
  // ---------------------------------------------------------------------------
  logic [7:0]  stamp_chars[$];
  logic [23:0] month_names [12] = '{"Jan", "Feb", "Mar", "Apr", "May", "Jun",
                                    "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"};

  // A quarter of the stray characters are full-range bytes, the rest are the
  // separators and digits that steer the parser.
  function automatic logic [7:0] stray_char();
    case ($urandom_range(0, 3))
      0: return lts_pkg::CH_SPACE;
      1: return lts_pkg::CH_COLON;
      2: return 8'(lts_pkg::CH_ZERO + $urandom_range(0, 9));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_field(input int value);
    int v;
    v = value;
    if ($urandom_range(0, 19) == 0) v = $urandom_range(100, 999);
    if (v >= 100) stamp_chars.push_back(8'(lts_pkg::CH_ZERO + v / 100));
    if (v >= 10 || $urandom_range(0, 1) == 1) begin
      stamp_chars.push_back(8'(lts_pkg::CH_ZERO + (v / 10) % 10));
    end
    stamp_chars.push_back(8'(lts_pkg::CH_ZERO + v % 10));
    if ($urandom_range(0, 15) == 0) stamp_chars.push_back(stray_char());
  endtask

  task automatic build_stamp();
    int          pick;
    int          colons;
    int          cut;
    logic [23:0] name;
    stamp_chars.delete();
    if ($urandom_range(0, 9) >= 7) begin
      repeat ($urandom_range(1, 10)) begin
        stamp_chars.push_back(($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 255))
                                                          : stray_char());
      end
      return;
    end
    pick = $urandom_range(0, 9);
    if (pick < 8) name = month_names[$urandom_range(0, 11)];
    else if (pick == 8) name = {lts_pkg::CH_LO_E, 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255))};
    else name = 24'($urandom);
    stamp_chars.push_back(name[23:16]);
    stamp_chars.push_back(name[15:8]);
    stamp_chars.push_back(name[7:0]);
    repeat ($urandom_range(0, 3)) stamp_chars.push_back(lts_pkg::CH_SPACE);
    add_field($urandom_range(1, 31));
    repeat (($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 2)) begin
      stamp_chars.push_back(lts_pkg::CH_SPACE);
    end
    pick = $urandom_range(0, 9);
    colons = (pick == 0) ? 0 : (pick == 1) ? 1 : (pick == 9) ? 3 : 2;
    add_field($urandom_range(0, 29));
    if (colons >= 1) begin
      stamp_chars.push_back(lts_pkg::CH_COLON);
      add_field($urandom_range(0, 69));
    end
    if (colons >= 2) begin
      stamp_chars.push_back(lts_pkg::CH_COLON);
      add_field($urandom_range(0, 69));
    end
    if (colons == 3) begin
      stamp_chars.push_back(lts_pkg::CH_COLON);
      add_field($urandom_range(0, 9));
    end
    // Now and then the string ends early, even inside the month letters.
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, stamp_chars.size());
      while (stamp_chars.size() > cut) void'(stamp_chars.pop_back());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed strings, one character per row: character, last flag, whether a
  // timestamp is typed in, and that timestamp. All run at the reset year.
  //   "J" alone: the two missing month letters count as zero, giving July.
  //   A zero byte alone: an ordinary non-space, non-digit, giving December.
  //   "e" alone: the lowercase letter that also means January.
  //   "Oct", a 0xFF byte, "123 24:7": the byte is skipped inside the day, the
  //     day saturates at 99, the hour of 24 is out of range, and with only
  //     one colon the minute is dropped.
  //   "Mar 1 9:5:8": a plain stamp with one-digit fields.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [7:0]  ch;
    logic        last;
    logic        typed;
    logic [46:0] want;
  } stim_row_t;

  stim_row_t directed_rows [26] = '{
    {"J",               1'b1, 1'b1, 47'd20250700000000},
    {8'h00,             1'b1, 1'b1, 47'd20251200000000},
    {"e",               1'b1, 1'b1, 47'd20250100000000},
    {"O",               1'b0, 1'b0, 47'd0},
    {"c",               1'b0, 1'b0, 47'd0},
    {"t",               1'b0, 1'b0, 47'd0},
    {8'hFF,             1'b0, 1'b0, 47'd0},
    {"1",               1'b0, 1'b0, 47'd0},
    {"2",               1'b0, 1'b0, 47'd0},
    {"3",               1'b0, 1'b0, 47'd0},
    {lts_pkg::CH_SPACE, 1'b0, 1'b0, 47'd0},
    {"2",               1'b0, 1'b0, 47'd0},
    {"4",               1'b0, 1'b0, 47'd0},
    {lts_pkg::CH_COLON, 1'b0, 1'b0, 47'd0},
    {"7",               1'b1, 1'b1, 47'd20251099000000},
    {"M",               1'b0, 1'b0, 47'd0},
    {"a",               1'b0, 1'b0, 47'd0},
    {"r",               1'b0, 1'b0, 47'd0},
    {lts_pkg::CH_SPACE, 1'b0, 1'b0, 47'd0},
    {"1",               1'b0, 1'b0, 47'd0},
    {lts_pkg::CH_SPACE, 1'b0, 1'b0, 47'd0},
    {"9",               1'b0, 1'b0, 47'd0},
    {lts_pkg::CH_COLON, 1'b0, 1'b0, 47'd0},
    {"5",               1'b0, 1'b0, 47'd0},
    {lts_pkg::CH_COLON, 1'b0, 1'b0, 47'd0},
    {"8",               1'b1, 1'b1, 47'd20250301090508}
  };

  // Years for the random part: both ends of the legal range, a value beyond
  // 9999 that the block must clamp, two random values, and back to the reset.
  logic [13:0] year_plan [YEAR_STEPS];

  initial begin : run_stimulus
    int sent;
    bit no_gaps;
    year_plan[0] = 14'd0;
    year_plan[1] = lts_pkg::YEAR_MAX;
    year_plan[2] = 14'h3FFF;
    year_plan[3] = 14'($urandom_range(0, 16383));
    year_plan[4] = 14'($urandom_range(0, 9999));
    year_plan[5] = lts_pkg::YEAR_RESET;
    clear_parse();
    year_reg = lts_pkg::YEAR_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_char(directed_rows[i].ch, directed_rows[i].last, 1'b0,
                directed_rows[i].typed, directed_rows[i].want);
    end

    for (int p = 0; p < YEAR_STEPS; p++) begin
      // The year may only change while the converter is between strings and empty.
      in_valid <= 1'b0;
      settle();
      write_year(year_plan[p]);
      sent = 0;
      while (sent < CHARS_PER_YEAR) begin
        build_stamp();
        // Roughly one string in four goes out back to back with no gaps.
        no_gaps = ($urandom_range(0, 3) == 0);
        foreach (stamp_chars[k]) begin
          send_char(stamp_chars[k], k == stamp_chars.size() - 1, no_gaps, 1'b0, '0);
        end
        sent += stamp_chars.size();
      end
    end

    in_valid <= 1'b0;
    settle();
    if (fail_count == 0) begin
      $display("tb_log_timestamp_to_number passed");
    end else begin
      $display("tb_log_timestamp_to_number failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output side. out_ready stalls for a random number of cycles before each
  // word, with stretches of no stalling. The word is checked on the falling
  // edge before the rising edge that takes it.
  // ---------------------------------------------------------------------------
  initial begin : drain_dates
    int          stall;
    bit          steady;
    logic [46:0] want;
    steady = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 7) == 0) steady = !steady;
      stall = steady ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      if (pending_dates.size() == 0) begin
        $error("date_value: no word expected, actual %0d", out_date_value);
        fail_count++;
      end else begin
        want = pending_dates.pop_front();
        if (out_date_value !== want) begin
          $error("date_value: expected %0d, actual %0d", want, out_date_value);
          fail_count++;
        end
      end
      @(posedge clk);
    end
  end

  // A hung handshake shows up as a long run of cycles where neither side
  // moves a word.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_log_timestamp_to_number failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
